FILE: rtl/lpps_pkg.sv
// Shared types, constants, microcode and tables for line_position_pid_steer.
// No dependencies; every other RTL file but lpps_checker imports this package.
package lpps_pkg;

  localparam int unsigned SensorCount = 5;
  localparam int unsigned ErrW        = 12;  // table error, +-2000
  localparam int unsigned GainW       = 16;
  localparam int unsigned SpeedW      = 8;
  localparam int unsigned SumW        = 32;
  localparam int unsigned PrevW       = 16;
  localparam int unsigned DerivW      = 17;
  localparam int unsigned ProdW       = GainW + SumW;
  localparam int unsigned AccW        = ProdW + 1;
  localparam int unsigned CorrW       = 16;
  localparam int unsigned FracBits    = 12;  // Q4.12 gains
  localparam int unsigned StepW       = 3;
  localparam int unsigned Steps       = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_SPEED_CAP  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_INTEG,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_SCALE,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_SKIP_HALT,
    COND_WAIT_OUT
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ucode_t;

  // Sequencer to datapath: which op, and whether it executes this cycle.
  typedef struct packed {
    op_e  op;
    logic go;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic halt;
    logic out_free;
  } stat_t;

  localparam ucode_t UCODE [Steps] = '{
    '{op: OP_LOAD,  cond: COND_WAIT_IN,   target: 3'd0},
    '{op: OP_INTEG, cond: COND_SKIP_HALT, target: 3'd7},
    '{op: OP_MUL_P, cond: COND_NEXT,      target: 3'd0},
    '{op: OP_MUL_I, cond: COND_NEXT,      target: 3'd0},
    '{op: OP_MUL_D, cond: COND_NEXT,      target: 3'd0},
    '{op: OP_ACC,   cond: COND_NEXT,      target: 3'd0},
    '{op: OP_SCALE, cond: COND_NEXT,      target: 3'd0},
    '{op: OP_EMIT,  cond: COND_WAIT_OUT,  target: 3'd0}
  };

  // Line lost or all sensors black.
  function automatic logic sensor_halt(input logic [SensorCount-1:0] bits);
    return (bits == '0) || (bits == '1);
  endfunction

  // center - truncated weighted average of index*1000, per sensor pattern
  function automatic logic signed [ErrW-1:0] sensor_error(
    input logic [SensorCount-1:0] bits);
    logic signed [ErrW-1:0] e;
    case (bits)
      5'd1:    e = 12'sd2000;
      5'd2:    e = 12'sd1000;
      5'd3:    e = 12'sd1500;
      5'd4:    e = 12'sd0;
      5'd5:    e = 12'sd1000;
      5'd6:    e = 12'sd500;
      5'd7:    e = 12'sd1000;
      5'd8:    e = -12'sd1000;
      5'd9:    e = 12'sd500;
      5'd10:   e = 12'sd0;
      5'd11:   e = 12'sd667;
      5'd12:   e = -12'sd500;
      5'd13:   e = 12'sd334;
      5'd14:   e = 12'sd0;
      5'd15:   e = 12'sd500;
      5'd16:   e = -12'sd2000;
      5'd17:   e = 12'sd0;
      5'd18:   e = -12'sd500;
      5'd19:   e = 12'sd334;
      5'd20:   e = -12'sd1000;
      5'd21:   e = 12'sd0;
      5'd22:   e = -12'sd333;
      5'd23:   e = 12'sd250;
      5'd24:   e = -12'sd1500;
      5'd25:   e = -12'sd333;
      5'd26:   e = -12'sd666;
      5'd27:   e = 12'sd0;
      5'd28:   e = -12'sd1000;
      5'd29:   e = -12'sd250;
      5'd30:   e = -12'sd500;
      default: e = 12'sd0;  // halting patterns
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/lpps_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on lpps_pkg.
module lpps_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  lpps_pkg::stat_t stat_i,
  output lpps_pkg::ctrl_t ctrl_o,
  output logic           in_ready_o
);
  import lpps_pkg::*;

  logic [StepW-1:0] pc_q, pc_d;
  ucode_t           word;
  logic             go;

  assign word = UCODE[pc_q];

  always_comb begin
    case (word.cond)
      COND_WAIT_IN:   go = in_valid_i;
      COND_SKIP_HALT: go = !stat_i.halt;
      COND_WAIT_OUT:  go = stat_i.out_free;
      default:        go = 1'b1;
    endcase
  end

  always_comb begin
    case (word.cond)
      COND_WAIT_IN:   pc_d = go ? pc_q + 3'd1 : pc_q;
      COND_SKIP_HALT: pc_d = go ? pc_q + 3'd1 : word.target;
      COND_WAIT_OUT:  pc_d = go ? word.target : pc_q;
      default:        pc_d = pc_q + 3'd1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.go   = go;
  assign in_ready_o  = (word.cond == COND_WAIT_IN);

endmodule

FILE: rtl/lpps_datapath.sv
// PID datapath: config registers, state, shared multiplier, accumulator,
// scaling, speed clamp and result register. Depends on lpps_pkg.
module lpps_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpps_pkg::ctrl_t               ctrl_i,
  output lpps_pkg::stat_t               stat_o,
  input  logic                          cfg_valid_i,
  input  logic [lpps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [4:0]                    sensor_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    left_speed_o,
  output logic [7:0]                    right_speed_o,
  output logic                          halted_o
);
  import lpps_pkg::*;

  logic signed [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [SpeedW-1:0]        base_q, max_q;
  logic signed [SumW-1:0]   esum_q;
  logic signed [PrevW-1:0]  prev_q;
  logic signed [ErrW-1:0]   err_q;
  logic                     halt_q;
  logic signed [DerivW-1:0] deriv_q;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [AccW-1:0]   acc_q;
  logic signed [CorrW-1:0]  corr_q, corr_d;
  logic                     out_valid_q;
  logic [SpeedW-1:0]        left_q, right_q;
  logic                     halted_q;

  logic signed [GainW-1:0]  mul_a;
  logic signed [SumW-1:0]   mul_b;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   esum_d;
  logic signed [AccW-1:0]   biased;
  logic signed [AccW-FracBits-1:0] quo;
  logic signed [SpeedW+9:0] left_raw, right_raw;
  logic                     emit;

  function automatic logic [SpeedW-1:0] clamp_speed(
    input logic signed [SpeedW+9:0] v, input logic [SpeedW-1:0] hi);
    logic [SpeedW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({10'd0, hi})) begin
      r = hi;
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 16'sd123;
      gain_i_q <= 16'sd0;
      gain_d_q <= 16'sd2048;
      base_q   <= 8'd150;
      max_q    <= 8'd255;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_P:     gain_p_q <= cfg_data_i;
        REG_GAIN_I:     gain_i_q <= cfg_data_i;
        REG_GAIN_D:     gain_d_q <= cfg_data_i;
        REG_BASE_SPEED: base_q   <= cfg_data_i[SpeedW-1:0];
        REG_SPEED_CAP:  max_q    <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // saturating integral
  always_comb begin
    sum_wide = (SumW+1)'(esum_q) + (SumW+1)'(err_q);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      esum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      esum_d = sum_wide[SumW-1:0];
    end
  end

  // PID state; written only for items that steer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      prev_q <= '0;
    end else if (ctrl_i.op == OP_INTEG && ctrl_i.go) begin
      esum_q <= esum_d;
      prev_q <= PrevW'(err_q);
    end
  end

  // shared 16x32 multiplier operand select
  always_comb begin
    case (ctrl_i.op)
      OP_MUL_I: begin
        mul_a = gain_i_q;
        mul_b = esum_q;
      end
      OP_MUL_D: begin
        mul_a = gain_d_q;
        mul_b = SumW'(deriv_q);
      end
      default: begin
        mul_a = gain_p_q;
        mul_b = SumW'(err_q);
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Q4.12 scale, truncating toward zero, then 16-bit saturation
  always_comb begin
    biased = acc_q + (acc_q[AccW-1] ? AccW'(4095) : AccW'(0));
    quo    = biased[AccW-1:FracBits];
    if (quo > (AccW-FracBits)'(32767)) begin
      corr_d = 16'sh7FFF;
    end else if (quo < -(AccW-FracBits)'(32768)) begin
      corr_d = 16'sh8000;
    end else begin
      corr_d = quo[CorrW-1:0];
    end
  end

  always_comb begin
    left_raw  = $signed({10'd0, base_q}) - (SpeedW+10)'(corr_q);
    right_raw = $signed({10'd0, base_q}) + (SpeedW+10)'(corr_q);
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD && ctrl_i.go) begin
      err_q  <= sensor_error(sensor_bits_i);
      halt_q <= sensor_halt(sensor_bits_i);
    end
    if (ctrl_i.op == OP_INTEG) begin
      deriv_q <= DerivW'(err_q) - DerivW'(prev_q);
    end
    if (ctrl_i.op == OP_MUL_P || ctrl_i.op == OP_MUL_I || ctrl_i.op == OP_MUL_D) begin
      prod_q <= prod_d;
    end
    case (ctrl_i.op)
      OP_MUL_I:          acc_q <= AccW'(prod_q);
      OP_MUL_D, OP_ACC:  acc_q <= acc_q + AccW'(prod_q);
      default: ;
    endcase
    if (ctrl_i.op == OP_SCALE) begin
      corr_q <= corr_d;
    end
  end

  assign emit = (ctrl_i.op == OP_EMIT) && ctrl_i.go;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      halted_q <= halt_q;
      left_q   <= halt_q ? '0 : clamp_speed(left_raw, max_q);
      right_q  <= halt_q ? '0 : clamp_speed(right_raw, max_q);
    end
  end

  assign stat_o.halt     = halt_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = left_q;
  assign right_speed_o   = right_q;
  assign halted_o        = halted_q;

endmodule

FILE: rtl/line_position_pid_steer.sv
// Top level of the PID line-follower steering block: sequencer plus datapath.
// Depends on lpps_pkg, lpps_seq and lpps_datapath.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_ready_o  sensor_bits_i[4:0]
// out       source     out_valid_o/out_ready_i left_speed_o, right_speed_o, halted_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i[2:0], cfg_data_i[15:0]
//
// One item at a time. A steering item runs the whole 8-step microprogram:
// transfer in, then the remaining steps to a loaded result register (integral,
// three passes through the single shared 16x32 multiplier, accumulate,
// scale, emit). A halting item (no sensor or all sensors on the line)
// skips to the emit step. The next transfer in is taken right
// after the emit step, even while the result still waits.
// The emit step holds while the result register is full and not being
// taken. cfg is always ready; writes to unused indexes are dropped.
// Reset (async, active low) restores the register defaults and clears
// the integral and previous error.
module line_position_pid_steer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  sensor_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  left_speed_o,
  output logic [7:0]  right_speed_o,
  output logic        halted_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lpps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpps_pkg::CfgDataW-1:0] cfg_data_i
);
  import lpps_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // config writes are never stalled
  assign cfg_ready_o = 1'b1;

  lpps_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  lpps_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sensor_bits_i (sensor_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .halted_o      (halted_o)
  );

endmodule

FILE: rtl/lpps_checker.sv
// Port-level checks for line_position_pid_steer, attached by bind.
// Depends only on the top level's port list.
module lpps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] left_speed_o,
  input logic [7:0] right_speed_o,
  input logic       halted_o
);

  // a stop result always commands zero speed
  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> left_speed_o == 8'd0 && right_speed_o == 8'd0)
    else $error("halted result with nonzero speed");

  // one item at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while item in flight");

  // a result is loaded only from the emit step, never while input is open
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a working step");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_speed_o)
      && $stable(right_speed_o) && $stable(halted_o))
    else $error("stalled result changed");

endmodule

bind line_position_pid_steer lpps_checker u_lpps_checker (.*);

FILE: tb/lpps_steer_checker.sv
// Passive checker for line_position_pid_steer: tracks cfg writes, predicts each steering
// command from the sensor transfers and compares it with the out channel.
// Depends on lpps_pkg.
module lpps_steer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [4:0]                    sensor_bits_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [7:0]                    left_speed_i,
  input  logic [7:0]                    right_speed_i,
  input  logic                          halted_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lpps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpps_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpps_pkg::*;

  localparam int Center    = (int'(SensorCount) - 1) * 500;
  localparam int MaxPrints = 50;

  typedef struct {
    logic [7:0] left;
    logic [7:0] right;
    logic       halted;
  } steer_cmd_t;

  steer_cmd_t expected_cmds [$];

  logic signed [15:0] gain_p, gain_i, gain_d;
  logic [7:0]         base_speed, speed_cap;
  int                 error_sum;
  shortint            prev_error;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < MaxPrints) $display("checker: mismatch: %s", msg);
    fail_count_o++;
  endtask

  function automatic int clamp_speed(input int v, input int hi);
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Steering law; updates the integral and previous error unless halting.
  task automatic predict_steer(input logic [4:0] bits, output steer_cmd_t cmd);
    int     weighted, active, position, err, deriv;
    longint sum, acc, corr;
    weighted = 0;
    active   = 0;
    for (int i = 0; i < int'(SensorCount); i++) begin
      if (bits[i]) begin
        weighted += i * 1000;
        active++;
      end
    end
    if (active == 0 || active == int'(SensorCount)) begin
      cmd = '{left: 8'd0, right: 8'd0, halted: 1'b1};
      return;
    end
    position = weighted / active;
    err      = Center - position;
    sum      = longint'(error_sum) + longint'(err);
    if (sum > longint'(32'sh7fff_ffff)) sum = longint'(32'sh7fff_ffff);
    if (sum < -longint'(64'sh8000_0000)) sum = -longint'(64'sh8000_0000);
    error_sum = int'(sum);
    deriv     = err - int'(prev_error);
    acc  = longint'(gain_p) * longint'(err) + longint'(gain_i) * longint'(error_sum)
         + longint'(gain_d) * longint'(deriv);
    corr = acc / 4096;  // truncates toward zero
    if (corr > 32767) corr = 32767;
    if (corr < -32768) corr = -32768;
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    prev_error = shortint'(err);
    cmd.left   = 8'(clamp_speed(int'(base_speed) - int'(corr), int'(speed_cap)));
    cmd.right  = 8'(clamp_speed(int'(base_speed) + int'(corr), int'(speed_cap)));
    cmd.halted = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_cmd_t want, got;
    if (!rst_ni) begin
      gain_p       = 16'sd123;
      gain_i       = 16'sd0;
      gain_d       = 16'sd2048;
      base_speed   = 8'd150;
      speed_cap    = 8'd255;
      error_sum    = 0;
      prev_error   = 0;
      expected_cmds.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_GAIN_P:     gain_p = cfg_data_i;
          REG_GAIN_I:     gain_i = cfg_data_i;
          REG_GAIN_D:     gain_d = cfg_data_i;
          REG_BASE_SPEED: base_speed = cfg_data_i[7:0];
          REG_SPEED_CAP:  speed_cap = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_steer(sensor_bits_i, want);
        expected_cmds.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{left: left_speed_i, right: right_speed_i, halted: halted_i};
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result l=%0d r=%0d h=%b with none expected",
                                    got.left, got.right, got.halted));
        end else begin
          want = expected_cmds.pop_front();
          if (got.left !== want.left)
            report_mismatch($sformatf("left_speed %0d, want %0d", got.left, want.left));
          if (got.right !== want.right)
            report_mismatch($sformatf("right_speed %0d, want %0d", got.right, want.right));
          if (got.halted !== want.halted)
            report_mismatch($sformatf("halted %b, want %b", got.halted, want.halted));
        end
      end
      pending_o = expected_cmds.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Top of the line_position_pid_steer testbench: clock, reset, stimulus and verdict.
// Depends on lpps_pkg, line_position_pid_steer and lpps_steer_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpps_pkg::*;

  localparam int PhaseCount  = 9;    // phase 0 directed, the rest random
  localparam int PhaseItems  = 250;
  localparam int HoldPhase   = 3;    // phase in which the receiver stalls for long
  localparam int HoldCycles  = 300;
  localparam int TimeoutNs   = 5_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [4:0]          sensor_bits_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          left_speed_o;
  logic [7:0]          right_speed_o;
  logic                halted_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;

  // Shared between stimulus and the receiver process.
  bit calm;           // no idling on either side
  bit hold_off_req;   // ask the receiver for one long stall

  line_position_pid_steer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sensor_bits_i (sensor_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .halted_o      (halted_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lpps_steer_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .sensor_bits_i (sensor_bits_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_speed_i  (left_speed_o),
    .right_speed_i (right_speed_o),
    .halted_i      (halted_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop in case a handshake never completes.
  initial begin
    #(TimeoutNs);
    $display("tb: errors");
    $finish;
  end

  // Mostly patterns a robot on a line would see (one sensor or two
  // neighbors), with lost line / all black and uniform noise mixed in.
  function automatic logic [4:0] pick_sensor();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 5'b00001 << $urandom_range(0, 4);
      4, 5:       return 5'b00011 << $urandom_range(0, 3);
      6:          return $urandom_range(0, 1) ? 5'b11111 : 5'b00000;
      default:    return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // One sensor transfer. Valid stays high after acceptance until the next
  // falling edge, where it either carries the next sample or drops for a gap.
  task automatic send_sensor(input logic [4:0] bits);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    sensor_bits_i = bits;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // One register write; valid is dropped by the caller once writes are done.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Random gain: half the time a modest one, otherwise anything in 16 bits.
  function automatic logic [CfgDataW-1:0] pick_gain();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 8191) - 4096);
    return 16'($urandom());
  endfunction

  // Settings per phase. Only called with the block idle.
  task automatic program_phase(input int p);
    logic [CfgDataW-1:0] gp, gi, gd, bs, ms;
    case (p)
      1: begin  // largest gains: the correction saturates high or low
        gp = 16'h7fff; gi = 16'h7fff; gd = 16'h7fff; bs = 16'd255; ms = 16'd255;
      end
      2: begin  // most negative gains, zero base speed
        gp = 16'h8000; gi = 16'h8000; gd = 16'h8000; bs = 16'd0; ms = 16'd255;
      end
      3: begin  // zero max speed forces both wheels to 0 without halting
        gp = 16'd123; gi = 16'd0; gd = 16'd2048; bs = 16'd128; ms = 16'd0;
      end
      4: begin  // pure integral term, max clamp below base
        gp = 16'd0; gi = 16'd64; gd = 16'd0; bs = 16'd200; ms = 16'd180;
      end
      default: begin
        gp = pick_gain();
        gi = pick_gain();
        gd = pick_gain();
        // upper byte is noise the block drops
        bs = 16'($urandom());
        ms = $urandom_range(0, 3) == 0 ? 16'h00ff : 16'($urandom());
      end
    endcase
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_BASE_SPEED, bs);
    write_reg(REG_SPEED_CAP, ms);
    // indexes past the register list must be dropped
    for (int idx = int'(REG_SPEED_CAP) + 1; idx < 2 ** CfgIdxW; idx++)
      write_reg(CfgIdxW'(idx), 16'($urandom()));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: bursts of ready and stalls, one long stall on request,
  // always ready once the run goes calm.
  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
        hold_off_req = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          @(negedge clk_i);
          out_ready_i = 1'b1;
        end
      end else begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
      end
    end
  end

  // Directed samples under reset settings: lost line, all black, every
  // single sensor, pairs, and four of the patterns whose average truncates.
  logic [4:0] directed [25] = '{
    5'd0,  5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd3,  5'd24,
    5'd11, 5'd13, 5'd26, 5'd22, 5'd29, 5'd23, 5'd7,  5'd28, 5'd10,
    5'd21, 5'd14, 5'd30, 5'd15, 5'd17, 5'd0,  5'd31
  };

  initial begin
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sensor_bits_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) program_phase(p);
      if (p == PhaseCount - 1) calm = 1'b1;
      // keep offering samples while the receiver sits on a full result
      if (p == HoldPhase) hold_off_req = 1'b1;
      if (p == 0) begin
        foreach (directed[k]) send_sensor(directed[k]);
      end else begin
        repeat (PhaseItems) send_sensor(pick_sensor());
      end
      @(negedge clk_i);
      in_valid_i = 1'b0;
      // every sample yields one command, so no pending means idle
      while (pending != 0) @(negedge clk_i);
    end

    repeat (2 * Steps) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lpps_pkg.sv
rtl/lpps_seq.sv
rtl/lpps_datapath.sv
rtl/line_position_pid_steer.sv
rtl/lpps_checker.sv
tb/lpps_steer_checker.sv
tb/tb.sv
